// ----- rtl/pmc_pkg.sv -----
`default_nettype none

package pmc_pkg;

	// mask geometry and coordinate widths
	localparam int MASK_SIDE  = 64;
	localparam int COORD_BITS = 12;
	localparam int ROW_BITS   = 64;
	localparam int ROW_AW     = (MASK_SIDE > 1) ? $clog2(MASK_SIDE) : 1;
	localparam int CNT_W      = $clog2(MASK_SIDE + 1);
	localparam int SH_W       = $clog2(ROW_BITS);
	localparam int LEN_W      = $clog2(ROW_BITS + 1);
	localparam int CW         = COORD_BITS + 2;
	localparam int W_LIMIT    = (MASK_SIDE < ROW_BITS) ? MASK_SIDE : ROW_BITS;
	localparam int H_LIMIT    = MASK_SIDE;

	// operation codes
	localparam logic [1:0] OP_LOAD_LEFT  = 2'd0;
	localparam logic [1:0] OP_LOAD_RIGHT = 2'd1;
	localparam logic [1:0] OP_TEST       = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_LEFT_W  = 2'd0;
	localparam logic [1:0] CFG_LEFT_H  = 2'd1;
	localparam logic [1:0] CFG_RIGHT_W = 2'd2;
	localparam logic [1:0] CFG_RIGHT_H = 2'd3;

	localparam logic [6:0] CFG_RESET_SIZE = 7'd64;

	typedef logic signed [CW-1:0] coord_t;

	// per-test scan setup handed from the bounds unit to the scan control
	typedef struct packed {
		logic                active;
		logic [CNT_W-1:0]    rows;
		logic [ROW_AW-1:0]   lrow;
		logic [ROW_AW-1:0]   rrow;
		logic [SH_W-1:0]     lsh;
		logic [SH_W-1:0]     rsh;
		logic [ROW_BITS-1:0] mask;
	} scan_setup_t;

	function automatic coord_t span_w(input logic [6:0] w);
		logic [31:0] v;
		begin
			v = 32'(w);
			if (v > 32'(W_LIMIT)) v = 32'(W_LIMIT);
			return coord_t'(v[CW-1:0]);
		end
	endfunction

	function automatic coord_t span_h(input logic [6:0] h);
		logic [31:0] v;
		begin
			v = 32'(h);
			if (v > 32'(H_LIMIT)) v = 32'(H_LIMIT);
			return coord_t'(v[CW-1:0]);
		end
	endfunction

	function automatic coord_t cmax(input coord_t a, input coord_t b);
		return (a > b) ? a : b;
	endfunction

	function automatic coord_t cmin(input coord_t a, input coord_t b);
		return (a < b) ? a : b;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/pixel_mask_collision_core.sv -----
// Pixel-perfect collision between two binary masks held in row memories.
// Input channel (in_valid/in_ready) carries one item per transaction:
// operation 0 or 1 writes row_bits into row row_index of the left or right
// mask, operation 2 tests the region against both masks placed at their
// origins. Every item gives exactly one result on the output channel
// (out_valid/out_ready, field hit), hit being 0 for loads.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) sets the mask
// sizes; cfg_ready is always high.
// A load or an unknown operation gives its result in the next cycle. A test
// first turns the overlap of the region and both masks into the scan setup
// in the bounds unit's registers during the setup state, then reads one row
// of each mask per cycle from the two row memories over the rows shared by
// the region and both masks (0 to MASK_SIDE), then folds in the last row.
// One item is in work at a time; the next is taken once the result register
// is free or being taken, so a stalled receiver holds the input side.
// Reset clears control state and sets all mask sizes to 64; mask rows stay
// undefined until loaded.
`default_nettype none

module pixel_mask_collision_core
	import pmc_pkg::*;
(
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [1:0]                   operation,
	input  wire logic [5:0]                   row_index,
	input  wire logic [ROW_BITS-1:0]          row_bits,
	input  wire logic signed [COORD_BITS-1:0] region_x,
	input  wire logic signed [COORD_BITS-1:0] region_y,
	input  wire logic signed [COORD_BITS-1:0] region_w,
	input  wire logic signed [COORD_BITS-1:0] region_h,
	input  wire logic signed [COORD_BITS-1:0] left_origin_x,
	input  wire logic signed [COORD_BITS-1:0] left_origin_y,
	input  wire logic signed [COORD_BITS-1:0] right_origin_x,
	input  wire logic signed [COORD_BITS-1:0] right_origin_y,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic                              hit,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [1:0]                   cfg_index,
	input  wire logic [6:0]                   cfg_data
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SETUP = 2'd1;
	localparam logic [1:0] ST_SCAN  = 2'd2;

	logic [1:0]          state_q;
	logic [6:0]          left_w_q, left_h_q, right_w_q, right_h_q;
	logic [CNT_W-1:0]    idx_q;
	logic                rd_valid_s1;
	logic                acc_hit_q;
	logic                out_valid_q;
	logic                out_hit_q;
	logic                in_acc;
	logic                start;
	logic                is_load;
	logic                load_ok;
	logic [31:0]         row_index_ext;
	logic [ROW_AW-1:0]   waddr;
	logic [ROW_AW-1:0]   raddr_l, raddr_r;
	logic                issue;
	logic                finish;
	logic                row_match;
	logic                result;
	logic [ROW_BITS-1:0] l_rd, r_rd;
	scan_setup_t         setup;

	// input handshake
	assign in_ready = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign in_acc   = in_valid && in_ready;
	assign start    = in_acc && (operation == OP_TEST);
	assign is_load  = (operation == OP_LOAD_LEFT) || (operation == OP_LOAD_RIGHT);

	// row write address, loads beyond the mask are dropped
	assign row_index_ext = 32'(row_index);
	assign load_ok       = row_index_ext < 32'(MASK_SIDE);
	assign waddr         = row_index_ext[ROW_AW-1:0];

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_w_q  <= CFG_RESET_SIZE;
			left_h_q  <= CFG_RESET_SIZE;
			right_w_q <= CFG_RESET_SIZE;
			right_h_q <= CFG_RESET_SIZE;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_LEFT_W:  left_w_q  <= cfg_data;
				CFG_LEFT_H:  left_h_q  <= cfg_data;
				CFG_RIGHT_W: right_w_q <= cfg_data;
				CFG_RIGHT_H: right_h_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// overlap computation
	pmc_bounds u_bounds (
		.clk            (clk),
		.start          (start),
		.region_x       (region_x),
		.region_y       (region_y),
		.region_w       (region_w),
		.region_h       (region_h),
		.left_origin_x  (left_origin_x),
		.left_origin_y  (left_origin_y),
		.right_origin_x (right_origin_x),
		.right_origin_y (right_origin_y),
		.left_width     (left_w_q),
		.left_height    (left_h_q),
		.right_width    (right_w_q),
		.right_height   (right_h_q),
		.setup          (setup)
	);

	// row scan addresses
	assign issue   = (state_q == ST_SCAN) && setup.active && (idx_q < setup.rows);
	assign finish  = (state_q == ST_SCAN) && !issue;
	assign raddr_l = setup.lrow + idx_q[ROW_AW-1:0];
	assign raddr_r = setup.rrow + idx_q[ROW_AW-1:0];

	pmc_row_ram u_left_ram (
		.clk   (clk),
		.we    (in_acc && (operation == OP_LOAD_LEFT) && load_ok),
		.waddr (waddr),
		.wdata (row_bits),
		.re    (issue),
		.raddr (raddr_l),
		.rdata (l_rd)
	);

	pmc_row_ram u_right_ram (
		.clk   (clk),
		.we    (in_acc && (operation == OP_LOAD_RIGHT) && load_ok),
		.waddr (waddr),
		.wdata (row_bits),
		.re    (issue),
		.raddr (raddr_r),
		.rdata (r_rd)
	);

	// common solid pixel in the row pair read last cycle
	assign row_match = |((l_rd >> setup.lsh) & (r_rd >> setup.rsh) & setup.mask);
	assign result    = acc_hit_q | (rd_valid_s1 & row_match);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			rd_valid_s1 <= 1'b0;
			acc_hit_q   <= 1'b0;
		end else begin
			rd_valid_s1 <= issue;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					idx_q     <= '0;
					acc_hit_q <= 1'b0;
					state_q   <= ST_SCAN;
				end
				ST_SCAN: begin
					if (issue) begin
						idx_q <= idx_q + CNT_W'(1);
					end
					if (rd_valid_s1 && row_match) begin
						acc_hit_q <= 1'b1;
					end
					if (finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_hit_q   <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
			out_hit_q   <= result;
		end else if (in_acc && !start) begin
			out_valid_q <= 1'b1;
			out_hit_q   <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign hit       = out_hit_q;

	// result slot is free whenever a test finishes
	a_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		finish |-> !out_valid_q)
		else $error("test finished while result register busy");

	// row data only returns during a scan
	a_rd_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid_s1 |-> (state_q == ST_SCAN))
		else $error("row read outstanding outside scan");

	// a load gives a zero result at the next edge
	a_load_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && is_load) |=> (out_valid_q && !out_hit_q))
		else $error("load result missing");

	// a test always passes through setup
	a_test_setup: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> (state_q == ST_SETUP))
		else $error("test did not enter setup");

endmodule

`default_nettype wire

// ----- rtl/pmc_row_ram.sv -----
`default_nettype none

module pmc_row_ram
	import pmc_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                we,
	input  wire logic [ROW_AW-1:0]   waddr,
	input  wire logic [ROW_BITS-1:0] wdata,
	input  wire logic                re,
	input  wire logic [ROW_AW-1:0]   raddr,
	output logic      [ROW_BITS-1:0] rdata
);

	logic [ROW_BITS-1:0] mem [MASK_SIDE];

	// one write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// one read port, registered data
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/pmc_bounds.sv -----
`default_nettype none

module pmc_bounds
	import pmc_pkg::*;
(
	input  wire logic                         clk,
	input  wire logic                         start,
	input  wire logic signed [COORD_BITS-1:0] region_x,
	input  wire logic signed [COORD_BITS-1:0] region_y,
	input  wire logic signed [COORD_BITS-1:0] region_w,
	input  wire logic signed [COORD_BITS-1:0] region_h,
	input  wire logic signed [COORD_BITS-1:0] left_origin_x,
	input  wire logic signed [COORD_BITS-1:0] left_origin_y,
	input  wire logic signed [COORD_BITS-1:0] right_origin_x,
	input  wire logic signed [COORD_BITS-1:0] right_origin_y,
	input  wire logic [6:0]                   left_width,
	input  wire logic [6:0]                   left_height,
	input  wire logic [6:0]                   right_width,
	input  wire logic [6:0]                   right_height,
	output scan_setup_t                       setup
);

	coord_t rx, ry, rw, rh, lx, ly, qx, qy;
	coord_t x0_c, x1_c, y0_c, y1_c;
	coord_t x0_s1, x1_s1, y0_s1, y1_s1, lx_s1, ly_s1, qx_s1, qy_s1;
	logic   nonempty_s1;
	coord_t dy, dly, dqy, dlx, dqx, dx;
	scan_setup_t setup_c;
	scan_setup_t setup_s2;

	// overlap of region and both masks
	always_comb begin
		rx = coord_t'(region_x);
		ry = coord_t'(region_y);
		rw = coord_t'(region_w);
		rh = coord_t'(region_h);
		lx = coord_t'(left_origin_x);
		ly = coord_t'(left_origin_y);
		qx = coord_t'(right_origin_x);
		qy = coord_t'(right_origin_y);
		x0_c = cmax(rx, cmax(lx, qx));
		x1_c = cmin(rx + rw, cmin(lx + span_w(left_width), qx + span_w(right_width)));
		y0_c = cmax(ry, cmax(ly, qy));
		y1_c = cmin(ry + rh, cmin(ly + span_h(left_height), qy + span_h(right_height)));
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x0_s1       <= x0_c;
			x1_s1       <= x1_c;
			y0_s1       <= y0_c;
			y1_s1       <= y1_c;
			lx_s1       <= lx;
			ly_s1       <= ly;
			qx_s1       <= qx;
			qy_s1       <= qy;
			nonempty_s1 <= (rw > coord_t'(0)) && (rh > coord_t'(0));
		end
	end

	// row range, start rows, bit offsets and column mask
	always_comb begin
		dy  = y1_s1 - y0_s1;
		dly = y0_s1 - ly_s1;
		dqy = y0_s1 - qy_s1;
		dlx = x0_s1 - lx_s1;
		dqx = x0_s1 - qx_s1;
		dx  = x1_s1 - x0_s1;
		setup_c.active = nonempty_s1 && (x1_s1 > x0_s1) && (y1_s1 > y0_s1);
		setup_c.rows   = dy[CNT_W-1:0];
		setup_c.lrow   = dly[ROW_AW-1:0];
		setup_c.rrow   = dqy[ROW_AW-1:0];
		setup_c.lsh    = dlx[SH_W-1:0];
		setup_c.rsh    = dqx[SH_W-1:0];
		setup_c.mask   = ~({ROW_BITS{1'b1}} << dx[LEN_W-1:0]);
	end

	always_ff @(posedge clk) begin
		setup_s2 <= setup_c;
	end

	assign setup = setup_s2;

endmodule

`default_nettype wire
